// File: rtl/lsts_pkg.sv
// Shared types, constants and the brightness curve for the LED star twinkle sequencer.
package lsts_pkg;

	// Sizes of the design.
	localparam int STAR_COUNT   = 32;
	localparam int CURVE_LENGTH = 64;
	localparam int PALETTE_SIZE = 16;
	localparam int TABLE_LEN    = 64;

	// Field widths fixed by the interface.
	localparam int STAR_W  = 5;
	localparam int DELAY_W = 8;
	localparam int COLOR_W = 4;
	localparam int BRIGHT_W = 8;

	// Derived widths.
	localparam int STAR_AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
	localparam int POS_W   = $clog2(CURVE_LENGTH + 2);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_FRAME_PERIOD  = 2'd0,
		REG_MAX_DELAY     = 2'd1,
		REG_PALETTE_COUNT = 2'd2
	} cfg_reg_t;

	// Configuration register set.
	typedef struct packed {
		logic [7:0] frame_period;
		logic [7:0] max_delay;
		logic [4:0] palette_count;
	} cfg_t;

	// Per-star state as held in one memory word.
	typedef struct packed {
		logic [DELAY_W-1:0] delay_left;
		logic [7:0]         frame_count;
		logic [POS_W-1:0]   curve_position;
		logic [COLOR_W-1:0] star_color;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// State of a star that has not been touched since reset.
	localparam entry_t ENTRY_RESET = '{
		delay_left:     '0,
		frame_count:    '0,
		curve_position: POS_W'(CURVE_LENGTH),
		star_color:     '0
	};

	// Result of one update.
	typedef struct packed {
		logic                emit;
		logic [BRIGHT_W-1:0] brightness;
		logic [COLOR_W-1:0]  color_index;
	} result_t;

	// Built-in brightness curve.
	localparam logic [7:0] CURVE_TABLE [TABLE_LEN] = '{
		8'd4,   8'd16,  8'd64,  8'd255, 8'd255, 8'd232, 8'd211, 8'd192,
		8'd175, 8'd159, 8'd145, 8'd132, 8'd120, 8'd110, 8'd100, 8'd91,
		8'd83,  8'd75,  8'd68,  8'd62,  8'd57,  8'd52,  8'd47,  8'd43,
		8'd39,  8'd35,  8'd32,  8'd29,  8'd27,  8'd24,  8'd22,  8'd20,
		8'd18,  8'd17,  8'd15,  8'd14,  8'd13,  8'd11,  8'd10,  8'd10,
		8'd9,   8'd8,   8'd7,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,
		8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd3,   8'd2,   8'd2,
		8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1
	};

	// Curve lookup; positions past the table read as dark.
	function automatic logic [7:0] curve_value(input logic [7:0] pos);
		logic [7:0] v;
		v = '0;
		if (pos < 8'(TABLE_LEN)) begin
			v = CURVE_TABLE[pos[5:0]];
		end
		return v;
	endfunction

endpackage

// File: rtl/lsts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/lsts_update.sv
// Next-state and result logic for one star update.
module lsts_update (
	input  lsts_pkg::cfg_t                       cfg,
	input  lsts_pkg::entry_t                     cur,
	input  logic [lsts_pkg::DELAY_W-1:0]         new_delay,
	input  logic [lsts_pkg::COLOR_W-1:0]         new_color,
	output lsts_pkg::entry_t                     nxt,
	output lsts_pkg::result_t                    res
);

	logic [lsts_pkg::POS_W-1:0] pos_adv;
	logic [7:0]                 frame_adv;
	logic [8:0]                 pal_eff;
	logic [8:0]                 pal_top;
	logic [lsts_pkg::COLOR_W-1:0] color_pick;
	logic [lsts_pkg::DELAY_W-1:0] delay_pick;

	// Frame divider: step the curve when the divider is exhausted.
	always_comb begin
		if (cur.frame_count == '0) begin
			pos_adv   = cur.curve_position + lsts_pkg::POS_W'(1);
			frame_adv = cfg.frame_period;
		end else begin
			pos_adv   = cur.curve_position;
			frame_adv = cur.frame_count - 8'd1;
		end
	end

	// Restart color, saturated to the palette in use.
	always_comb begin
		pal_eff = 9'(cfg.palette_count);
		if (pal_eff > 9'(lsts_pkg::PALETTE_SIZE)) begin
			pal_eff = 9'(lsts_pkg::PALETTE_SIZE);
		end
		pal_top    = pal_eff - 9'd1;
		color_pick = '0;
		if (pal_eff > 9'd1) begin
			if (9'(new_color) > pal_top) begin
				color_pick = pal_top[lsts_pkg::COLOR_W-1:0];
			end else begin
				color_pick = new_color;
			end
		end
	end

	// Restart delay, clamped below the configured bound.
	always_comb begin
		if (cfg.max_delay == '0) begin
			delay_pick = '0;
		end else if (new_delay >= cfg.max_delay) begin
			delay_pick = cfg.max_delay - 8'd1;
		end else begin
			delay_pick = new_delay;
		end
	end

	// Choose among countdown, curve step and restart.
	always_comb begin
		nxt             = cur;
		res.emit        = 1'b0;
		res.brightness  = lsts_pkg::curve_value(8'(pos_adv));
		res.color_index = cur.star_color;
		if (cur.delay_left != '0) begin
			nxt.delay_left = cur.delay_left - 8'd1;
		end else begin
			nxt.frame_count = frame_adv;
			if (pos_adv < lsts_pkg::POS_W'(lsts_pkg::CURVE_LENGTH)) begin
				nxt.curve_position = pos_adv;
				res.emit           = 1'b1;
			end else begin
				nxt.curve_position = '0;
				nxt.star_color     = color_pick;
				nxt.delay_left     = delay_pick;
			end
		end
	end

endmodule

// File: rtl/led_star_twinkle_sequencer.sv
// Top level of the LED star twinkle sequencer: config registers, state memory and output.
//
// Each beat on start updates one star: the star's state word is read from the state RAM at
// the accepting edge and written back at the end of the following cycle, and busy is high
// for that write-back cycle, so no new beat is taken before the word is written back.
// When the star is on its brightness curve, strobe is high for
// exactly one cycle, the cycle right after the busy cycle (busy drops as strobe rises),
// with star_out, brightness and color_index; the result cannot be held off by the
// receiver. A star index beyond the star count is taken and dropped without busy. Stars
// not updated since reset read as idle at the curve end through per-star valid bits, so
// no clearing pass is needed.
module led_star_twinkle_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lsts_pkg::STAR_W-1:0]    star_index,
	input  logic [lsts_pkg::DELAY_W-1:0]   new_delay,
	input  logic [lsts_pkg::COLOR_W-1:0]   new_color,
	output logic                           strobe,
	output logic [lsts_pkg::STAR_W-1:0]    star_out,
	output logic [lsts_pkg::BRIGHT_W-1:0]  brightness,
	output logic [lsts_pkg::COLOR_W-1:0]   color_index,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [7:0]                     cfg_data
);

	lsts_pkg::cfg_t    cfg_q;
	logic              accept;
	logic              valid_s1;
	logic [lsts_pkg::STAR_AW-1:0]  star_s1;
	logic [lsts_pkg::DELAY_W-1:0]  delay_s1;
	logic [lsts_pkg::COLOR_W-1:0]  color_s1;
	logic              hit_s1;
	logic [lsts_pkg::STAR_COUNT-1:0] written_q;
	logic [lsts_pkg::ENTRY_W-1:0]  ram_rdata;
	lsts_pkg::entry_t  cur_entry;
	lsts_pkg::entry_t  nxt_entry;
	lsts_pkg::result_t res;
	logic              strobe_q;
	logic [lsts_pkg::STAR_W-1:0]   star_q;
	logic [lsts_pkg::BRIGHT_W-1:0] bright_q;
	logic [lsts_pkg::COLOR_W-1:0]  color_q;

	// A beat is taken when idle; out-of-range stars start no update.
	assign accept = start && !busy &&
		(9'(star_index) < 9'(lsts_pkg::STAR_COUNT));
	assign busy   = valid_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period  <= 8'd0;
			cfg_q.max_delay     <= 8'd255;
			cfg_q.palette_count <= 5'd1;
		end else if (cfg_we) begin
			unique case (lsts_pkg::cfg_reg_t'(cfg_index))
				lsts_pkg::REG_FRAME_PERIOD:  cfg_q.frame_period  <= cfg_data;
				lsts_pkg::REG_MAX_DELAY:     cfg_q.max_delay     <= cfg_data;
				lsts_pkg::REG_PALETTE_COUNT: cfg_q.palette_count <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Update stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Beat payload held alongside the RAM read.
	always_ff @(posedge clk) begin
		if (accept) begin
			star_s1  <= lsts_pkg::STAR_AW'(star_index);
			delay_s1 <= new_delay;
			color_s1 <= new_color;
			hit_s1   <= written_q[lsts_pkg::STAR_AW'(star_index)];
		end
	end

	// Per-star written flags; an unwritten star reads as the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (valid_s1) begin
			written_q[star_s1] <= 1'b1;
		end
	end

	// Per-star state memory.
	lsts_ram #(
		.WIDTH (lsts_pkg::ENTRY_W),
		.DEPTH (lsts_pkg::STAR_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (star_s1),
		.wdata (nxt_entry),
		.raddr (lsts_pkg::STAR_AW'(star_index)),
		.rdata (ram_rdata)
	);

	assign cur_entry = hit_s1 ? lsts_pkg::entry_t'(ram_rdata) : lsts_pkg::ENTRY_RESET;

	lsts_update u_update (
		.cfg       (cfg_q),
		.cur       (cur_entry),
		.new_delay (delay_s1),
		.new_color (color_s1),
		.nxt       (nxt_entry),
		.res       (res)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1 && res.emit;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && res.emit) begin
			star_q   <= lsts_pkg::STAR_W'(star_s1);
			bright_q <= res.brightness;
			color_q  <= res.color_index;
		end
	end

	assign strobe      = strobe_q;
	assign star_out    = star_q;
	assign brightness  = bright_q;
	assign color_index = color_q;

endmodule
